### rtl/sha256_message_digest_assert.svh
// Assertion macros shared by the digest block.
`ifndef SHA256_MESSAGE_DIGEST_ASSERT_SVH
`define SHA256_MESSAGE_DIGEST_ASSERT_SVH
// Property that must hold on every clock edge outside reset.
`define SHA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Property checked during reset as well.
`define SHA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### rtl/sha_pkg.sv
// Package with the SHA-256 constants, types and round functions.
package sha_pkg;
	localparam int unsigned WordW = 32;
	localparam int unsigned BufDepth = 16;
	localparam int unsigned BufAw = 4;
	localparam int unsigned CountW = 61;

	localparam logic [7:0] PadMark = 8'h80;

	typedef logic [WordW-1:0] word_t;

	// Round constants.
	function automatic word_t round_k(input logic [5:0] idx);
		word_t k [64] = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
			32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
			32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
			32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
			32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[idx];
	endfunction

	// Initial hash values.
	function automatic word_t init_hash(input logic [2:0] idx);
		word_t h [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		return h[idx];
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t sig0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	// Request from the byte packer to the compression engine.
	typedef struct packed {
		logic start;
	} comp_req_t;
endpackage

### rtl/sha256_message_digest.sv
// Top level of the byte-serial SHA-256 digest block.
// Usage:
// The slave channel s_tdata carries one message byte per beat. s_tuser
// marks whether the byte belongs to the message, s_tlast ends the message.
// A beat with s_tlast set and s_tuser clear ends the message without a byte.
// The master channel gives eight digest beats, word 0 first; m_tuser is the
// word index and m_tlast marks word 7.
// Throughput: bytes are taken one per cycle until a block of 64 is full;
// the single round unit then runs 64 rounds, during which no byte is
// taken. After the end beat, padding and length words are written and
// one or two compressions follow before the first digest beat.
// Reset clears the byte count and loads the initial hash values; the block
// buffer RAM needs no clearing. When the receiver stalls, the digest beat
// holds and no new message byte is taken until all eight are delivered.
module sha256_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // msg_byte
	input  logic        s_tuser,  // byte_valid
	input  logic        s_tlast,  // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // digest_word
	output logic [2:0]  m_tuser,  // word_index
	output logic        m_tlast   // last_word
);
	import sha_pkg::*;

	logic      we;
	logic [BufAw-1:0] waddr;
	word_t     wdata;
	logic [BufAw-1:0] raddr;
	word_t     rdata;
	comp_req_t req;
	logic      busy;
	logic      done;
	logic      reinit;
	logic [2:0] hidx;
	word_t     hword;

	// Block buffer memory.
	sha_ram #(.Width(WordW), .Depth(BufDepth)) u_buf (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// Round engine.
	sha_core u_core (
		.clk(clk), .arst_n(arst_n), .req(req), .blk_rdata(rdata), .blk_raddr(raddr),
		.busy(busy), .done(done), .reinit(reinit), .hidx(hidx), .hword(hword)
	);

	// Packer and output sequencer.
	sha_packer u_pack (
		.clk(clk), .arst_n(arst_n), .msg_byte(s_tdata), .byte_valid(s_tuser),
		.end_of_message(s_tlast), .in_fire(s_tvalid && s_tready), .in_ready(s_tready),
		.we(we), .waddr(waddr), .wdata(wdata), .req(req), .core_busy(busy),
		.core_done(done), .reinit(reinit), .hidx(hidx),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_idx(m_tuser)
	);

	assign m_tdata = hword;
	assign m_tlast = (m_tuser == 3'd7);
endmodule

### rtl/sha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module sha_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/sha_core.sv
// Compression engine: one round per cycle over a block held in RAM.
module sha_core (
	input  logic             clk,
	input  logic             arst_n,
	input  sha_pkg::comp_req_t req,
	input  sha_pkg::word_t   blk_rdata,
	output logic [3:0]       blk_raddr,
	output logic             busy,
	output logic             done,
	input  logic             reinit,
	input  logic [2:0]       hidx,
	output sha_pkg::word_t   hword
);
	import sha_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_ADD  = 3'b100
	} state_t;

	state_t     state_q;
	logic [6:0] rnd_q;
	word_t      h_q [8];
	word_t      v_q [8];
	word_t      w_q [16];
	word_t      wt;
	word_t      t1;
	word_t      t2;
	word_t      wnew;

	// The schedule window holds the last sixteen words; the first sixteen
	// come from the block RAM in the cycle after their address.
	assign blk_raddr = rnd_q[3:0];
	assign wnew = w_q[0] + sig0(w_q[1]) + w_q[9] + sig1(w_q[14]);
	assign wt = (rnd_q < 7'd17) ? blk_rdata : wnew;
	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ round_k(6'(rnd_q - 7'd1)) + wt;
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign busy = (state_q != S_IDLE);
	assign hword = h_q[hidx];

	// Round sequencer: rnd_q 0 is the RAM prefetch cycle, 1..64 are rounds.
	// While idle the counter rests at zero so that word 0 is always prefetched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rnd_q   <= '0;
			done    <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (reinit) begin
						for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
					end
					if (req.start) begin
						state_q <= S_RUN;
						rnd_q   <= 7'd1;
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					end
				end
				S_RUN: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wt;
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					if (rnd_q == 7'd64) begin
						state_q <= S_ADD;
					end
					rnd_q <= rnd_q + 7'd1;
				end
				S_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					state_q <= S_IDLE;
					rnd_q   <= '0;
					done    <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "sha256_message_digest_assert.svh"
	`SHA_ASSERT(a_done_after_add, done |-> $past(state_q == S_ADD), "done without add")
	`SHA_ASSERT(a_idle_prefetch, (state_q == S_IDLE) |-> (rnd_q == 7'd0), "idle round count")
	`SHA_ASSERT(a_run_rnd, (state_q == S_RUN) |-> (rnd_q >= 7'd1 && rnd_q <= 7'd64), "round")
endmodule

### rtl/sha_packer.sv
// Byte packer, padding sequencer and digest output sequencer; writes block words into the buffer RAM.
module sha_packer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     msg_byte,
	input  logic           byte_valid,
	input  logic           end_of_message,
	input  logic           in_fire,
	output logic           in_ready,
	output logic           we,
	output logic [3:0]     waddr,
	output sha_pkg::word_t wdata,
	output sha_pkg::comp_req_t req,
	input  logic           core_busy,
	input  logic           core_done,
	output logic           reinit,
	output logic [2:0]     hidx,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     out_idx
);
	import sha_pkg::*;

	typedef enum logic [5:0] {
		P_BYTES = 6'b000001,
		P_WAIT  = 6'b000010,
		P_PAD   = 6'b000100,
		P_LEN   = 6'b001000,
		P_FIN   = 6'b010000,
		P_OUT   = 6'b100000
	} pstate_t;

	pstate_t     st_q;
	logic [CountW-1:0] cnt_q;
	word_t       acc_q;
	logic [3:0]  pw_q;
	logic        second_q;
	logic        fin_q;
	logic [2:0]  oi_q;
	logic [1:0]  lane;
	word_t       acc_n;
	logic [63:0] bits;

	assign lane = cnt_q[1:0];
	assign bits = {cnt_q, 3'b000};
	assign in_ready = (st_q == P_BYTES) && !core_busy;
	assign hidx = oi_q;
	assign out_idx = oi_q;
	assign out_valid = (st_q == P_OUT);

	always_comb begin
		acc_n = acc_q;
		case (lane)
			2'd0: acc_n = {msg_byte, 24'h0};
			2'd1: acc_n[23:16] = msg_byte;
			2'd2: acc_n[15:8] = msg_byte;
			default: acc_n[7:0] = msg_byte;
		endcase
	end

	// Write port selection and padding sequence.
	always_comb begin
		we = 1'b0;
		waddr = cnt_q[5:2];
		wdata = acc_n;
		req = '0;
		reinit = 1'b0;
		if (st_q == P_BYTES && in_fire && byte_valid && lane == 2'd3) begin
			we = 1'b1;
		end
		if (st_q == P_BYTES && in_fire && byte_valid && cnt_q[5:0] == 6'd63) begin
			req.start = 1'b1;
		end
		if (st_q == P_PAD) begin
			we = 1'b1;
			waddr = pw_q;
			wdata = '0;
			if (pw_q == cnt_q[5:2] && !second_q) begin
				case (lane)
					2'd0: wdata = {PadMark, 24'h0};
					2'd1: wdata = {acc_q[31:24], PadMark, 16'h0};
					2'd2: wdata = {acc_q[31:16], PadMark, 8'h0};
					default: wdata = {acc_q[31:8], PadMark};
				endcase
			end
			if (pw_q == 4'd15 && (second_q || cnt_q[5:0] >= 6'd56)) begin
				req.start = !second_q && cnt_q[5:0] >= 6'd56;
			end
		end
		if (st_q == P_LEN) begin
			we = 1'b1;
			waddr = pw_q;
			wdata = (pw_q == 4'd14) ? bits[63:32] : bits[31:0];
			req.start = (pw_q == 4'd15);
		end
		if (st_q == P_OUT && out_ready && oi_q == 3'd7) begin
			reinit = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= P_BYTES;
			cnt_q <= '0;
			pw_q <= '0;
			second_q <= 1'b0;
			fin_q <= 1'b0;
			oi_q <= '0;
		end else begin
			unique case (st_q)
				P_BYTES: begin
					if (in_fire) begin
						if (byte_valid) begin
							acc_q <= acc_n;
							cnt_q <= cnt_q + 1'b1;
						end
						if (end_of_message) begin
							st_q <= P_WAIT;
							fin_q <= 1'b1;
						end else if (byte_valid && cnt_q[5:0] == 6'd63) begin
							st_q <= P_WAIT;
						end
					end
				end
				P_WAIT: begin
					if (!core_busy && !req.start) begin
						if (fin_q) begin
							st_q <= P_PAD;
							pw_q <= cnt_q[5:2];
							second_q <= 1'b0;
						end else begin
							st_q <= P_BYTES;
						end
					end
				end
				P_PAD: begin
					pw_q <= pw_q + 4'd1;
					if (!second_q && cnt_q[5:0] < 6'd56 && pw_q == 4'd13) begin
						st_q <= P_LEN;
						pw_q <= 4'd14;
					end else if (pw_q == 4'd15) begin
						if (!second_q) begin
							st_q <= P_FIN;
						end else begin
							st_q <= P_LEN;
							pw_q <= 4'd14;
						end
					end else if (second_q && pw_q == 4'd13) begin
						st_q <= P_LEN;
						pw_q <= 4'd14;
					end
				end
				P_FIN: begin
					if (core_done) begin
						st_q <= P_PAD;
						pw_q <= 4'd0;
						second_q <= 1'b1;
					end
				end
				P_LEN: begin
					pw_q <= pw_q + 4'd1;
					if (pw_q == 4'd15) begin
						st_q <= P_FIN;
						second_q <= 1'b1;
						fin_q <= 1'b0;
					end
				end
				P_OUT: begin
					if (out_ready) begin
						oi_q <= oi_q + 3'd1;
						if (oi_q == 3'd7) begin
							st_q <= P_BYTES;
							cnt_q <= '0;
						end
					end
				end
				default: st_q <= P_BYTES;
			endcase
			// The final compression completes into the output phase.
			if (st_q == P_FIN && core_done && second_q && !fin_q) begin
				st_q <= P_OUT;
				oi_q <= '0;
				second_q <= 1'b0;
			end
		end
	end

	`include "sha256_message_digest_assert.svh"
	`SHA_ASSERT(a_no_accept_busy, in_fire |-> !core_busy, "byte taken while compressing")
	`SHA_ASSERT(a_out_idle_core, out_valid |-> !core_busy, "digest while busy")
	`SHA_ASSERT(a_reinit_last, reinit |-> (oi_q == 3'd7), "reinit early")
endmodule

### tb/tb_sha256_message_digest.sv
// Testbench for the byte-serial SHA-256 digest block, checked against a local SHA-256 predictor.
module tb_sha256_message_digest;
	import sha_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       keep;
		logic       ends;
	} msg_beat_t;

	typedef struct {
		word_t      word;
		logic [2:0] idx;
		logic       last;
	} digest_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;  // msg_byte
	logic        s_tuser;  // byte_valid
	logic        s_tlast;  // end_of_message
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;  // digest_word
	logic [2:0]  m_tuser;  // word_index
	logic        m_tlast;  // last_word

	// Predictor state.
	word_t        hash_state [8];
	word_t        blk [16];
	logic [60:0]  byte_count;
	digest_beat_t digest_queue [$];

	int  failures;
	bit  quiet_tail;
	int  beats_sent;

	sha256_message_digest i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("tb_sha256_message_digest: errors");
		$finish;
	end

	function automatic word_t rr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One SHA-256 block compression into the predicted chaining state.
	task automatic predict_compress();
		word_t w [64];
		word_t v [8];
		word_t t1;
		word_t t2;
		for (int i = 0; i < 16; i++) w[i] = blk[i];
		for (int i = 16; i < 64; i++) begin
			w[i] = w[i-16] + w[i-7]
				+ (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3))
				+ (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10));
		end
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(r[5:0]) + w[r];
			t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] += v[i];
	endtask

	task automatic place_byte(input int pos, input logic [7:0] b);
		blk[pos/4][(3 - pos%4)*8 +: 8] = b;
	endtask

	task automatic restart_hash();
		for (int i = 0; i < 8; i++) hash_state[i] = init_hash(i[2:0]);
		byte_count = '0;
	endtask

	// Works out the digest beats caused by one accepted message beat.
	task automatic predict_digest(input msg_beat_t b);
		int          pos;
		logic [63:0] bits;
		digest_beat_t d;
		if (b.keep) begin
			pos = byte_count[5:0];
			place_byte(pos, b.data);
			byte_count++;
			if (pos == 63) predict_compress();
		end
		if (b.ends) begin
			pos = byte_count[5:0];
			place_byte(pos, PadMark);
			for (int i = pos + 1; i < 64; i++) place_byte(i, 8'h00);
			if (pos >= 56) begin
				predict_compress();
				for (int i = 0; i < 16; i++) blk[i] = '0;
			end
			bits = {byte_count, 3'b000};
			blk[14] = bits[63:32];
			blk[15] = bits[31:0];
			predict_compress();
			for (int i = 0; i < 8; i++) begin
				d.word = hash_state[i];
				d.idx  = i[2:0];
				d.last = (i == 7);
				digest_queue.push_back(d);
			end
			restart_hash();
		end
	endtask

	// Sends one beat, at times after a random gap, except in the quiet tail.
	task automatic send_beat(input msg_beat_t b);
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b.data;
		s_tuser  <= b.keep;
		s_tlast  <= b.ends;
		do @(posedge clk); while (!s_tready);
		predict_digest(b);
		beats_sent++;
	endtask

	task automatic send_message(input int len, input logic [7:0] fill, input bit rnd);
		msg_beat_t b;
		for (int i = 0; i < len; i++) begin
			b.data = rnd ? 8'($urandom) : fill;
			b.keep = 1'b1;
			b.ends = 1'b0;
			if (rnd && $urandom_range(0, 15) == 0) b.keep = 1'b0;
			send_beat(b);
		end
		b.data = 8'($urandom);
		b.keep = rnd ? 1'($urandom) : 1'b0;
		b.ends = 1'b1;
		send_beat(b);
	endtask

	// Receiver: random stalls and the check against the oldest expectation.
	initial begin
		digest_beat_t e;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet_tail && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (digest_queue.size() == 0) begin
					$error("digest beat with nothing expected: %h", m_tdata);
					failures++;
				end else begin
					e = digest_queue.pop_front();
					if (m_tdata !== e.word) begin
						$error("digest_word expected %h got %h", e.word, m_tdata);
						failures++;
					end
					if (m_tuser !== e.idx) begin
						$error("word_index expected %0d got %0d", e.idx, m_tuser);
						failures++;
					end
					if (m_tlast !== e.last) begin
						$error("last_word expected %0b got %0b", e.last, m_tlast);
						failures++;
					end
				end
			end
		end
	end

	// Directed table: empty message, ignored bytes, end marks.
	msg_beat_t directed [] = '{
		'{8'h00, 1'b0, 1'b1},                        // empty message
		'{8'h61, 1'b1, 1'b0}, '{8'h62, 1'b1, 1'b0},
		'{8'h63, 1'b1, 1'b1},                        // "abc", byte on end mark
		'{8'hff, 1'b0, 1'b0}, '{8'h55, 1'b0, 1'b0},  // ignored bytes
		'{8'hff, 1'b1, 1'b0}, '{8'h00, 1'b1, 1'b0},
		'{8'haa, 1'b0, 1'b1}                         // bare end mark after bytes
	};

	initial begin
		int lens [] = '{55, 56, 63, 64};
		int msg_len;
		failures   = 0;
		quiet_tail = 1'b0;
		beats_sent = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		s_tlast  = 1'b0;
		for (int i = 0; i < 16; i++) blk[i] = '0;
		restart_hash();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_beat(directed[i]);
			// The predicted first word of the empty message is checked against the well-known hash while still queued.
			if (i == 0 && digest_queue.size() > 0 && digest_queue[0].word !== 32'he3b0c442) begin
				$error("digest_word expected %h got predicted %h", 32'he3b0c442,
					digest_queue[0].word);
				failures++;
			end
		end
		// Lengths around the one- and two-block padding boundary.
		foreach (lens[i]) send_message(lens[i], 8'hff, 1'b0);

		// Hold off until every expected digest has been delivered.
		s_tvalid <= 1'b0;
		while (digest_queue.size() != 0) @(posedge clk);

		// Random messages, mostly short, some crossing block boundaries.
		while (beats_sent < 410) begin
			if (beats_sent > 340) quiet_tail = 1'b1;
			msg_len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(50, 70))
				: int'($urandom_range(0, 20));
			if (msg_len > 409 - beats_sent) msg_len = 409 - beats_sent;
			send_message(msg_len, 8'h00, 1'b1);
		end
		s_tvalid <= 1'b0;
		s_tuser  <= 1'b0;
		s_tlast  <= 1'b0;

		while (digest_queue.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (failures == 0 && digest_queue.size() == 0)
			$display("tb_sha256_message_digest: clean");
		else
			$display("tb_sha256_message_digest: errors");
		$finish;
	end
endmodule

### files.f
+incdir+rtl
rtl/sha_pkg.sv
rtl/sha_ram.sv
rtl/sha_core.sv
rtl/sha_packer.sv
rtl/sha256_message_digest.sv
tb/tb_sha256_message_digest.sv
